### rtl/core/block_request_checker_splitter_unit_assert.svh
// assertion macros shared by the block request checker and splitter
// every macro samples on clk and is held off while rst is high
`ifndef BLOCK_REQUEST_CHECKER_SPLITTER_UNIT_ASSERT_SVH
`define BLOCK_REQUEST_CHECKER_SPLITTER_UNIT_ASSERT_SVH

// same-cycle implication
`define BRCS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("brcs same-cycle check failed");

// next-cycle implication
`define BRCS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("brcs next-cycle check failed");

`endif

### rtl/core/brcs_pkg.sv
// ----------------------------------------------------------------------------
// brcs_pkg
// Types and codes shared by the block request checker and splitter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package brcs_pkg;

  localparam int MAX_RESULTS = 32;
  localparam int SEC_W       = 64;
  localparam int LEN_W       = 18;
  localparam int OFF_W       = 17;
  localparam int CFG_IDX_W   = 3;

  // request kinds
  localparam logic [1:0] MODE_READ    = 2'd0;
  localparam logic [1:0] MODE_WRITE   = 2'd1;
  localparam logic [1:0] MODE_FLUSH   = 2'd2;
  localparam logic [1:0] MODE_DISCARD = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_INVAL  = 3'd1;
  localparam logic [2:0] ST_RANGE  = 3'd2;
  localparam logic [2:0] ST_ROFS   = 3'd3;
  localparam logic [2:0] ST_NOTSUP = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DISK_SECTORS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISK_WRITABLE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FLUSH_SUP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DISCARD_SUP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SECURE_SUP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DISCARD_GRAN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DISCARD_ALIGN  = 3'd6;

  typedef struct packed {
    logic [1:0]       mode;
    logic [SEC_W-1:0] start_sector;
    logic [LEN_W-1:0] byte_length;
    logic [SEC_W-1:0] discard_count;
    logic             secure_erase;
  } brcs_in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [1:0]       op_kind;
    logic [SEC_W-1:0] chunk_sector;
    logic [SEC_W-1:0] chunk_count;
    logic [OFF_W-1:0] buffer_offset;
    logic             secure_flag;
    logic             last;
  } brcs_out_t;

  // operand pair fed to the shared divider
  typedef enum logic {
    DV_OFF,
    DV_CNT
  } brcs_div_sel_t;

  // shape of the result word to load
  typedef enum logic [1:0] {
    E_PLAIN,
    E_DISCARD,
    E_CHUNK
  } brcs_emit_sel_t;

  typedef struct packed {
    logic           load_req;
    logic           div_start;
    brcs_div_sel_t  div_sel;
    logic           chunk_init;
    logic           emit;
    brcs_emit_sel_t emit_sel;
    logic [2:0]     status;
  } brcs_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       len_bad;
    logic       dcount_zero;
    logic       flush_ok;
    logic       discard_feat_ok;
    logic       range_bad;
    logic       count_over;
    logic       write_denied;
    logic       grain_bad;
    logic       div_busy;
    logic       div_done;
    logic       div_rem_zero;
    logic       gs_zero;
    logic       as_over_sec;
    logic       slot_free;
    logic       chunk_last;
  } brcs_sts_t;

endpackage

`default_nettype wire

### rtl/core/brcs_divider.sv
// ----------------------------------------------------------------------------
// brcs_divider
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per
// cycle; only the remainder is kept. It holds until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module brcs_divider (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [31:0]      remainder
);

  logic [63:0] dvd;
  logic [31:0] dvs;
  logic [5:0]  step;
  logic [32:0] trial;
  logic        fits;

  // shift in the next dividend bit and test against the divisor
  assign trial = {remainder, dvd[63]};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 6'd1;
        if (step == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      dvd       <= dividend;
      dvs       <= divisor;
      remainder <= '0;
    end else if (busy) begin
      dvd <= {dvd[62:0], 1'b0};
      if (fits) begin
        remainder <= 32'(trial - {1'b0, dvs});
      end else begin
        remainder <= trial[31:0];
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/brcs_datapath.sv
// ----------------------------------------------------------------------------
// brcs_datapath
// Configuration registers, request registers, check logic, shared divider,
// chunk stepping and the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module brcs_datapath
  import brcs_pkg::*;
#(
  parameter int SECTOR_BYTES        = 512,
  parameter int PAGE_BYTES          = 4096,
  parameter int MAX_REQUEST_SECTORS = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]          cfg_data,
  input  wire brcs_in_t             in_data,
  input  wire brcs_cmd_t            cmd,
  output brcs_sts_t                 sts,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output brcs_out_t                 out_data
);

  localparam int PER_CHUNK = (PAGE_BYTES / SECTOR_BYTES > 0) ?
                             PAGE_BYTES / SECTOR_BYTES : 1;
  localparam int CHUNK_LIM = MAX_RESULTS * PER_CHUNK;
  localparam int LIMIT     = (MAX_REQUEST_SECTORS < CHUNK_LIM) ?
                             MAX_REQUEST_SECTORS : CHUNK_LIM;
  // sector size is a power of two, so bytes to sectors is a shift and a mask
  localparam int               SB_SHIFT = $clog2(SECTOR_BYTES);
  localparam logic [31:0]      SB_W     = 32'(SECTOR_BYTES);
  localparam logic [31:0]      SB_MASK  = 32'(SECTOR_BYTES - 1);
  localparam logic [LEN_W-1:0] LEN_MASK = SB_MASK[LEN_W-1:0];
  localparam logic [LEN_W-1:0] PC_W     = LEN_W'(PER_CHUNK);
  localparam logic [LEN_W-1:0] LIMIT_W  = LEN_W'(LIMIT);

  // configuration
  logic [63:0] disk_sectors;
  logic        disk_writable;
  logic        flush_supported;
  logic        discard_supported;
  logic        secure_supported;
  logic [31:0] gran_bytes;
  logic [31:0] align_bytes;

  // request and working registers
  brcs_in_t         req;
  logic [LEN_W-1:0] remaining;
  logic [SEC_W-1:0] cur_sec;
  logic [OFF_W-1:0] off;

  // divider
  logic        div_busy;
  logic        div_done;
  logic [31:0] div_rem;
  logic [63:0] div_dividend;
  logic [31:0] div_divisor;

  logic [LEN_W-1:0] count;
  logic [31:0]      gs;
  logic [31:0]      as_sec;
  logic [63:0]      range_cnt;
  logic [63:0]      room;
  logic [31:0]      gran_eff;
  logic [LEN_W-1:0] n;
  logic [31:0]      step_bytes;
  logic             slot_free;

  // configuration writes, indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      disk_sectors      <= '0;
      disk_writable     <= 1'b0;
      flush_supported   <= 1'b0;
      discard_supported <= 1'b0;
      secure_supported  <= 1'b0;
      gran_bytes        <= '0;
      align_bytes       <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DISK_SECTORS:  disk_sectors      <= cfg_data;
        REG_DISK_WRITABLE: disk_writable     <= cfg_data[0];
        REG_FLUSH_SUP:     flush_supported   <= cfg_data[0];
        REG_DISCARD_SUP:   discard_supported <= cfg_data[0];
        REG_SECURE_SUP:    secure_supported  <= cfg_data[0];
        REG_DISCARD_GRAN:  gran_bytes        <= cfg_data[31:0];
        REG_DISCARD_ALIGN: align_bytes       <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // byte quantities in whole sectors
  assign gran_eff = (gran_bytes == '0) ? SB_W : gran_bytes;
  assign count    = req.byte_length >> SB_SHIFT;
  assign gs       = gran_eff >> SB_SHIFT;
  assign as_sec   = align_bytes >> SB_SHIFT;

  // divider operand select
  always_comb begin
    div_dividend = '0;
    div_divisor  = gs;
    case (cmd.div_sel)
      DV_OFF: begin
        div_dividend = req.start_sector - 64'(as_sec);
      end
      DV_CNT: begin
        div_dividend = req.discard_count;
      end
      default: ;
    endcase
  end

  brcs_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .done      (div_done),
    .remainder (div_rem)
  );

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load_req) req <= in_data;
  end

  // chunk stepping
  assign n          = (remaining > PC_W) ? PC_W : remaining;
  assign step_bytes = 32'(n) * SB_W;

  always_ff @(posedge clk) begin
    if (cmd.chunk_init) begin
      remaining <= count;
      cur_sec   <= req.start_sector;
      off       <= '0;
    end else if (cmd.emit && cmd.emit_sel == E_CHUNK) begin
      remaining <= remaining - n;
      cur_sec   <= cur_sec + 64'(n);
      off       <= off + step_bytes[OFF_W-1:0];
    end
  end

  // range check on the request in flight
  assign range_cnt = (req.mode == MODE_DISCARD) ? req.discard_count : 64'(count);
  assign room      = disk_sectors - req.start_sector;

  assign slot_free = !out_valid || out_ready;

  always_comb begin
    sts.mode            = req.mode;
    sts.len_bad         = (req.byte_length == '0) ||
                          ((req.byte_length & LEN_MASK) != '0);
    sts.dcount_zero     = (req.discard_count == '0);
    sts.flush_ok        = flush_supported;
    sts.discard_feat_ok = discard_supported && (!req.secure_erase || secure_supported);
    sts.range_bad       = (disk_sectors == '0) || (req.start_sector >= disk_sectors) ||
                          (range_cnt > room);
    sts.count_over      = (count > LIMIT_W);
    sts.write_denied    = (req.mode == MODE_WRITE) && !disk_writable;
    sts.grain_bad       = ((gran_eff & SB_MASK) != '0) || ((align_bytes & SB_MASK) != '0);
    sts.div_busy        = div_busy;
    sts.div_done        = div_done;
    sts.div_rem_zero    = (div_rem == '0);
    sts.gs_zero         = (gs == '0);
    sts.as_over_sec     = (req.start_sector < 64'(as_sec));
    sts.slot_free       = slot_free;
    sts.chunk_last      = (remaining <= PC_W);
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.op_kind <= req.mode;
      case (cmd.emit_sel)
        E_DISCARD: begin
          out_data.status        <= ST_OK;
          out_data.chunk_sector  <= req.start_sector;
          out_data.chunk_count   <= req.discard_count;
          out_data.buffer_offset <= '0;
          out_data.secure_flag   <= req.secure_erase;
          out_data.last          <= 1'b1;
        end
        E_CHUNK: begin
          out_data.status        <= ST_OK;
          out_data.chunk_sector  <= cur_sec;
          out_data.chunk_count   <= 64'(n);
          out_data.buffer_offset <= off;
          out_data.secure_flag   <= 1'b0;
          out_data.last          <= (remaining <= PC_W);
        end
        default: begin
          out_data.status        <= cmd.status;
          out_data.chunk_sector  <= '0;
          out_data.chunk_count   <= '0;
          out_data.buffer_offset <= '0;
          out_data.secure_flag   <= 1'b0;
          out_data.last          <= 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/brcs_ctrl.sv
// ----------------------------------------------------------------------------
// brcs_ctrl
// Sequencer that walks one request through its checks, drives the shared
// divider and hands result words to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module brcs_ctrl
  import brcs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  output brcs_cmd_t      cmd,
  input  wire brcs_sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_CHK_RW,
    S_CHUNK,
    S_CHK_AS,
    S_DIV_OFF,
    S_DIV_CNT,
    S_EMIT
  } state_t;

  state_t         state, state_next;
  logic [2:0]     status, status_next;
  brcs_emit_sel_t sel, sel_next;

  // single-word finish request from the check steps
  logic           fin;
  logic [2:0]     fin_status;
  brcs_emit_sel_t fin_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      status <= ST_OK;
      sel    <= E_PLAIN;
    end else begin
      state  <= state_next;
      status <= status_next;
      sel    <= sel_next;
    end
  end

  always_comb begin
    state_next     = state;
    status_next    = status;
    sel_next       = sel;
    fin            = 1'b0;
    fin_status     = ST_OK;
    fin_sel        = E_PLAIN;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.div_sel    = DV_OFF;
    cmd.emit_sel   = sel;
    cmd.status     = status;

    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_DISPATCH;
        end
      end

      // first check by request kind
      S_DISPATCH: begin
        case (sts.mode)
          MODE_FLUSH: begin
            fin        = 1'b1;
            fin_status = sts.flush_ok ? ST_OK : ST_NOTSUP;
          end
          MODE_DISCARD: begin
            if (sts.dcount_zero) begin
              fin = 1'b1; fin_status = ST_INVAL;
            end else if (!sts.discard_feat_ok) begin
              fin = 1'b1; fin_status = ST_NOTSUP;
            end else if (sts.range_bad) begin
              fin = 1'b1; fin_status = ST_RANGE;
            end else begin
              state_next = S_CHK_AS;
            end
          end
          default: begin
            // length must be whole sectors and non-zero
            if (sts.len_bad) begin
              fin = 1'b1; fin_status = ST_INVAL;
            end else begin
              state_next = S_CHK_RW;
            end
          end
        endcase
      end

      S_CHK_RW: begin
        if (sts.count_over) begin
          fin = 1'b1; fin_status = ST_INVAL;
        end else if (sts.range_bad) begin
          fin = 1'b1; fin_status = ST_RANGE;
        end else if (sts.write_denied) begin
          fin = 1'b1; fin_status = ST_ROFS;
        end else begin
          cmd.chunk_init = 1'b1;
          sel_next       = E_CHUNK;
          status_next    = ST_OK;
          state_next     = S_CHUNK;
        end
      end

      // one page-sized word per free output slot
      S_CHUNK: begin
        cmd.emit_sel = E_CHUNK;
        if (sts.slot_free) begin
          cmd.emit = 1'b1;
          if (sts.chunk_last) state_next = S_IDLE;
        end
      end

      // grain and offset in whole sectors, start not below the offset
      S_CHK_AS: begin
        if (sts.grain_bad || sts.gs_zero || sts.as_over_sec) begin
          fin = 1'b1; fin_status = ST_INVAL;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DV_OFF;
          state_next    = S_DIV_OFF;
        end
      end

      // start past the offset on a granule boundary
      S_DIV_OFF: begin
        if (sts.div_done) begin
          if (!sts.div_rem_zero) begin
            fin = 1'b1; fin_status = ST_INVAL;
          end else begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DV_CNT;
            state_next    = S_DIV_CNT;
          end
        end
      end

      // count a whole number of granules
      S_DIV_CNT: begin
        if (sts.div_done) begin
          fin        = 1'b1;
          fin_status = sts.div_rem_zero ? ST_OK : ST_INVAL;
          fin_sel    = sts.div_rem_zero ? E_DISCARD : E_PLAIN;
        end
      end

      S_EMIT: begin
        if (sts.slot_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase

    // hand the single result word to the emit step
    if (fin) begin
      status_next = fin_status;
      sel_next    = fin_sel;
      state_next  = S_EMIT;
    end
  end

endmodule

`default_nettype wire

### rtl/core/block_request_checker_splitter_unit.sv
// ----------------------------------------------------------------------------
// block_request_checker_splitter_unit
// Checks block-device requests against the disk setup and splits accepted
// reads and writes into page-sized ring requests.
// ----------------------------------------------------------------------------
// One request is handled at a time; the next is taken once the last word of
// the current one is in the output register. A flush or a request refused
// at its first check passes through the dispatch and emit steps only, and a
// read or write refused on size, range or write protection also passes the
// read/write check step. An accepted read or write yields one output word
// per page-sized chunk, at most 32. A discard that clears its first checks
// runs up to two passes of the shared bit-serial divider (start offset, then
// count, each modulo the grain); the second pass is skipped when the start
// is off the grain. Output stalls delay every request at the steps that load
// its words. The sector size must be a power of two. Configuration writes
// are always ready and must only come while no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module block_request_checker_splitter_unit
  import brcs_pkg::*;
#(
  parameter int SECTOR_BYTES        = 512,
  parameter int PAGE_BYTES          = 4096,
  parameter int MAX_REQUEST_SECTORS = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]          cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire brcs_in_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output brcs_out_t                 out_data
);

  `include "block_request_checker_splitter_unit_assert.svh"

  brcs_cmd_t cmd;
  brcs_sts_t sts;

  assign cfg_ready = 1'b1;

  brcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  brcs_datapath #(
    .SECTOR_BYTES        (SECTOR_BYTES),
    .PAGE_BYTES          (PAGE_BYTES),
    .MAX_REQUEST_SECTORS (MAX_REQUEST_SECTORS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a word is only loaded into a free output slot
  `BRCS_ASSERT_IMP(a_emit_slot_free, cmd.emit, sts.slot_free)
  // the divider is never restarted mid-pass
  `BRCS_ASSERT_IMP(a_div_not_busy, cmd.div_start, !sts.div_busy)
  // a taken request blocks the input until it is done
  `BRCS_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // the final word of a request frees the input
  `BRCS_ASSERT_NXT(a_idle_after_last,
                   cmd.emit && (cmd.emit_sel != E_CHUNK || sts.chunk_last), in_ready)

endmodule

`default_nettype wire
